// File: hw/rtl/ttc_pkg.sv
package ttc_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int VIEW_ROWS  = 24;
  localparam int CELL_COUNT = COLUMNS * VIEW_ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  // Widths of internal state
  localparam int ADDR_W    = $clog2(CELL_COUNT);
  localparam int ROW_IDX_W = $clog2(VIEW_ROWS);
  localparam int COL_IDX_W = $clog2(COLUMNS);
  localparam int LEN_W     = $clog2(COLUMNS + 1);

  // Widths of the item and result fields
  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CHAR_SPACE};

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

// File: hw/rtl/ttc_addr.sv
module ttc_addr (
  input  logic [ttc_pkg::ROW_IDX_W-1:0] row,
  input  logic [ttc_pkg::LEN_W-1:0]     col,
  input  logic [ttc_pkg::ADDR_W-1:0]    base,
  input  logic                          use_row,
  output logic [ttc_pkg::ADDR_W-1:0]    sum
);

  logic [ttc_pkg::ADDR_W-1:0] row_base;
  logic [ttc_pkg::ADDR_W-1:0] opnd;

  // Row times the constant line length, or a plain base, plus a column offset
  always_comb begin
    row_base = ttc_pkg::ADDR_W'(row) * ttc_pkg::ADDR_W'(ttc_pkg::COLUMNS);
    opnd     = use_row ? row_base : base;
    sum      = opnd + ttc_pkg::ADDR_W'(col);
  end

endmodule

// File: hw/rtl/ttc_cell_ram.sv
module ttc_cell_ram (
  input  logic                       clk,
  input  ttc_pkg::mem_wr_t           wr,
  input  ttc_pkg::mem_rd_t           rd,
  output logic [ttc_pkg::CELL_W-1:0] rdata
);

  logic [ttc_pkg::CELL_W-1:0] mem [ttc_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// File: hw/rtl/ttc_ctrl.sv
module ttc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ttc_pkg::ATTR_W-1:0] cfg_wr_data,
  input  logic                       item_valid,
  input  ttc_pkg::item_t             item,
  output logic                       item_ready,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ttc_pkg::result_t           res,
  output ttc_pkg::mem_wr_t           mem_wr,
  output ttc_pkg::mem_rd_t           mem_rd,
  input  logic [ttc_pkg::CELL_W-1:0] mem_rdata
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [ttc_pkg::ADDR_W-1:0] LAST_ADDR =
    ttc_pkg::ADDR_W'(ttc_pkg::CELL_COUNT - 1);
  localparam logic [ttc_pkg::ADDR_W-1:0] COPY_END =
    ttc_pkg::ADDR_W'(ttc_pkg::COPY_COUNT);

  logic [2:0]                        state;
  logic [ttc_pkg::ADDR_W-1:0]        cnt;
  logic                              pend;
  logic [ttc_pkg::ADDR_W-1:0]        copy_dst;
  logic [ttc_pkg::ROW_IDX_W-1:0]     cur_row;
  logic [ttc_pkg::COL_IDX_W-1:0]     cur_col;
  logic [ttc_pkg::LEN_W-1:0]         row_len [ttc_pkg::VIEW_ROWS];
  logic [ttc_pkg::ATTR_W-1:0]        text_color;
  ttc_pkg::item_t                    item_q;
  logic                              rd_hit;
  logic                              scrolled_q;

  logic [ttc_pkg::COL_IDX_W:0]       col_inc;
  logic [ttc_pkg::ROW_IDX_W:0]       row_inc;
  logic [ttc_pkg::ROW_IDX_W-1:0]     row_dec;
  logic [ttc_pkg::LEN_W-1:0]         prev_len;
  logic                              is_nl;
  logic                              is_bs;
  logic [ttc_pkg::ROW_IDX_W-1:0]     tgt_row;
  logic [ttc_pkg::COL_IDX_W-1:0]     tgt_col;
  logic [ttc_pkg::ROW_IDX_W-1:0]     wr_row;
  logic [ttc_pkg::COL_IDX_W-1:0]     wr_col;
  logic                              len_we;
  logic [ttc_pkg::LEN_W-1:0]         len_val;
  logic                              row_adv;
  logic                              do_scroll;
  logic [ttc_pkg::ROW_IDX_W-1:0]     new_row;
  logic                              rd_in_range;
  logic                              copy_rd;
  logic [ttc_pkg::CELL_W-1:0]        blank;

  logic [ttc_pkg::ROW_IDX_W-1:0]     au_row;
  logic [ttc_pkg::LEN_W-1:0]         au_col;
  logic [ttc_pkg::ADDR_W-1:0]        au_base;
  logic                              au_use_row;
  logic [ttc_pkg::ADDR_W-1:0]        au_sum;

  ttc_addr u_addr (
    .row     (au_row),
    .col     (au_col),
    .base    (au_base),
    .use_row (au_use_row),
    .sum     (au_sum)
  );

  // Cursor movement for one put
  always_comb begin
    col_inc  = {1'b0, cur_col} + 1'b1;
    row_inc  = {1'b0, cur_row} + 1'b1;
    row_dec  = cur_row - 1'b1;
    prev_len = row_len[row_dec];
    is_nl    = item_q.char_code == ttc_pkg::CHAR_NEWLINE;
    is_bs    = item_q.char_code == ttc_pkg::CHAR_BACKSPACE;
    tgt_row  = cur_row;
    tgt_col  = cur_col;
    len_we   = 1'b0;
    len_val  = ttc_pkg::LEN_W'(cur_col);
    row_adv  = 1'b0;
    priority if (is_nl) begin
      len_we  = 1'b1;
      tgt_col = '0;
      row_adv = 1'b1;
    end else if (is_bs) begin
      if (cur_col != '0) begin
        tgt_col = cur_col - 1'b1;
      end else if (cur_row != '0) begin
        tgt_row = row_dec;
        tgt_col = (prev_len >= ttc_pkg::COLUMNS) ?
                  ttc_pkg::COL_IDX_W'(ttc_pkg::COLUMNS - 1) :
                  ttc_pkg::COL_IDX_W'(prev_len);
      end
    end else begin
      len_we = 1'b1;
      if (col_inc >= ttc_pkg::COLUMNS) begin
        len_val = ttc_pkg::LEN_W'(ttc_pkg::COLUMNS);
        tgt_col = '0;
        row_adv = 1'b1;
      end else begin
        len_val = ttc_pkg::LEN_W'(col_inc);
        tgt_col = ttc_pkg::COL_IDX_W'(col_inc);
      end
    end
    wr_row    = is_bs ? tgt_row : cur_row;
    wr_col    = is_bs ? tgt_col : cur_col;
    do_scroll = row_adv && (row_inc >= ttc_pkg::VIEW_ROWS);
    if (!row_adv) begin
      new_row = tgt_row;
    end else if (do_scroll) begin
      new_row = ttc_pkg::ROW_IDX_W'(ttc_pkg::VIEW_ROWS - 1);
    end else begin
      new_row = ttc_pkg::ROW_IDX_W'(row_inc);
    end
    rd_in_range = (item_q.read_row < ttc_pkg::VIEW_ROWS) &&
                  (item_q.read_col < ttc_pkg::COLUMNS);
    copy_rd = cnt < COPY_END;
    blank   = {text_color, ttc_pkg::CHAR_SPACE};
  end

  // Operands of the shared address unit
  always_comb begin
    au_row     = cur_row;
    au_col     = ttc_pkg::LEN_W'(cur_col);
    au_base    = cnt;
    au_use_row = 1'b1;
    unique case (state)
      S_EXEC: begin
        if (item_q.req_type == ttc_pkg::REQ_READ) begin
          au_row = ttc_pkg::ROW_IDX_W'(item_q.read_row);
          au_col = ttc_pkg::LEN_W'(item_q.read_col);
        end else begin
          au_row = wr_row;
          au_col = ttc_pkg::LEN_W'(wr_col);
        end
      end
      S_COPY: begin
        au_col     = ttc_pkg::LEN_W'(ttc_pkg::COLUMNS);
        au_use_row = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Cell store ports
  always_comb begin
    mem_wr.en   = 1'b0;
    mem_wr.addr = au_sum;
    mem_wr.data = blank;
    mem_rd.en   = 1'b0;
    mem_rd.addr = au_sum;
    unique case (state)
      S_INIT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = cnt;
        mem_wr.data = ttc_pkg::RESET_CELL;
      end
      S_EXEC: begin
        mem_wr.en = (item_q.req_type == ttc_pkg::REQ_PUT) && !is_nl;
        if (!is_bs) begin
          mem_wr.data = {text_color, item_q.char_code};
        end
        mem_rd.en = (item_q.req_type == ttc_pkg::REQ_READ) && rd_in_range;
      end
      S_COPY: begin
        mem_wr.en   = pend;
        mem_wr.addr = copy_dst;
        mem_wr.data = mem_rdata;
        mem_rd.en   = copy_rd;
      end
      S_FILL: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = cnt;
      end
      default: begin
      end
    endcase
  end

  assign item_ready     = state == S_IDLE;
  assign res_valid      = state == S_DONE;
  assign res.cursor_pos = ttc_pkg::POS_W'(au_sum);
  assign res.cell_data  = rd_hit ? mem_rdata : '0;
  assign res.scrolled   = scrolled_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      pend       <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      text_color <= ttc_pkg::RESET_ATTR;
      for (int i = 0; i < ttc_pkg::VIEW_ROWS; i++) begin
        row_len[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        text_color <= cfg_wr_data;
      end
      unique case (state)
        S_INIT: begin
          if (cnt == LAST_ADDR) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (item_q.req_type)
            ttc_pkg::REQ_PUT: begin
              cur_row <= new_row;
              cur_col <= tgt_col;
              if (len_we) begin
                row_len[cur_row] <= len_val;
              end
              if (do_scroll) begin
                cnt   <= '0;
                state <= S_COPY;
              end else begin
                state <= S_DONE;
              end
            end
            ttc_pkg::REQ_CLEAR: begin
              cur_row <= '0;
              cur_col <= '0;
              cnt     <= '0;
              for (int i = 0; i < ttc_pkg::VIEW_ROWS; i++) begin
                row_len[i] <= '0;
              end
              state <= S_FILL;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_COPY: begin
          if (copy_rd) begin
            cnt  <= cnt + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              for (int i = 0; i < ttc_pkg::VIEW_ROWS - 1; i++) begin
                row_len[i] <= row_len[i+1];
              end
              row_len[ttc_pkg::VIEW_ROWS-1] <= '0;
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          if (cnt == LAST_ADDR) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q <= item;
    end
    if (state == S_EXEC) begin
      rd_hit     <= (item_q.req_type == ttc_pkg::REQ_READ) && rd_in_range;
      scrolled_q <= (item_q.req_type == ttc_pkg::REQ_PUT) && do_scroll;
    end
    if (state == S_COPY && copy_rd) begin
      copy_dst <= cnt;
    end
  end

endmodule

// File: hw/rtl/text_terminal_console.sv
// Character terminal over a store of 24 rows by 80 text cells, each cell a
// 16-bit word with the attribute in the high byte and the character in the
// low byte. A put writes a character at the cursor in the current colour and
// advances; newline, backspace, wrap at the row end and scroll past the last
// row are handled as on a console. A clear blanks the view and homes the
// cursor, a read returns one cell, and every request yields one result with
// the linear cursor position. Requests are handled one at a time by a small
// sequencer that drives one address unit (row times line length, or a plain
// base, plus a column) and the single-port-write cell store. After reset a
// clearing pass writes every cell, and s_axis_tready stays low until it ends.
// A put, newline, backspace or read goes through an execute and a done state;
// a put that scrolls walks the store at one cell a cycle to move each row up,
// then blanks the last row; a clear blanks every cell. The next request is
// taken while an earlier result still waits on the master side.
module text_terminal_console (
  input  logic        clk,
  input  logic        rst,
  // Colour register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // cursor_pos[10:0], cell_data[26:11], scrolled[27]
);

  ttc_pkg::item_t             item;
  ttc_pkg::result_t           res;
  logic                       res_valid;
  logic                       res_ready;
  ttc_pkg::mem_wr_t           mem_wr;
  ttc_pkg::mem_rd_t           mem_rd;
  logic [ttc_pkg::CELL_W-1:0] mem_rdata;

  // Unpack the request; the top bits of tdata are padding
  assign item.req_type  = s_axis_tuser;
  assign item.char_code = s_axis_tdata[7:0];
  assign item.read_row  = s_axis_tdata[12:8];
  assign item.read_col  = s_axis_tdata[19:13];

  ttc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (s_axis_tvalid),
    .item        (item),
    .item_ready  (s_axis_tready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr      (mem_wr),
    .mem_rd      (mem_rd),
    .mem_rdata   (mem_rdata)
  );

  ttc_cell_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {4'b0, res.scrolled, res.cell_data, res.cursor_pos};
    end
  end

endmodule

// File: hw/rtl/ttc_checker.sv
module ttc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  localparam int  LAST_ROW_POS = (ttc_pkg::VIEW_ROWS - 1) * ttc_pkg::COLUMNS;
  localparam bit  POS_FITS     = ttc_pkg::CELL_COUNT <= 2048;

  // Clearing pass blocks requests and no result is pending after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready or result valid straight after reset");

  // A request keeps the block busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken on consecutive cycles");

  // A scroll always leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[27] |->
      !POS_FITS || (m_axis_tdata[10:0] >= LAST_ROW_POS))
    else $error("scrolled result with cursor above last row");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind text_terminal_console ttc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
